FILE: hdl/lrv_pkg.sv
// Shared types, constants and the CRC-32 byte update for the log record verifier.
package lrv_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int MAGIC_BYTES = 4;
    localparam int TYPE_INDEX = 5;
    localparam int LENGTH_FIRST = 6;
    localparam int LENGTH_END = 10;
    localparam int CRC_BYTES = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_OK       = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_CRC_ERROR = 2'd3
    } kind_t;

    // One byte of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/lrv_byte_if.sv
// Input channel that carries one record stream byte per transaction.
interface lrv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rec_byte;

    modport source (output valid, output rec_byte, input ready);
    modport sink (input valid, input rec_byte, output ready);
endinterface

FILE: hdl/lrv_result_if.sv
// Output channel that carries one payload byte or record status per transaction.
interface lrv_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [31:0] record_length;
    logic        last;

    modport source (
        output valid, output kind, output data_byte, output record_type,
        output record_length, output last, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input record_type,
        input record_length, input last, output ready
    );
endinterface

FILE: hdl/lrv_cfg_if.sv
// Configuration write channel that carries the expected record magic word.
interface lrv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/log_record_verifier.sv
// Log record verifier: header check, payload pass-through and CRC-32 check.
// An accepted byte's result, if it has one, is written to the output register in the next cycle.
// One byte per cycle unless stalled; the CRC update and counter step share that cycle.
// A new byte is accepted whenever the output register is empty or being drained.
// Reset (rst_n low, asynchronous) returns to the header phase with the CRC at all ones
// and clears the expected magic word to zero.
module log_record_verifier
    import lrv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lrv_byte_if.sink           records,
    lrv_result_if.source       results,
    lrv_cfg_if.sink            cfg
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC     = 2'd2,
        PH_UNUSED  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] magic_shift_reg, magic_shift_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [31:0] held_length_reg, held_length_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [31:0] record_magic_reg;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [7:0]  data_byte_reg;
    logic [7:0]  record_type_reg;
    logic [31:0] record_length_reg;
    logic        last_reg;

    logic        accept;
    logic        has_result;
    kind_t       res_kind;
    logic [7:0]  res_data;
    logic [31:0] crc_updated;
    logic [31:0] count_inc;
    logic [7:0]  b;

    assign b = records.rec_byte;
    assign records.ready = !out_valid_reg || results.ready;
    assign accept = records.valid && records.ready;
    assign cfg.ready = 1'b1;

    assign results.valid = out_valid_reg;
    assign results.kind = kind_reg;
    assign results.data_byte = data_byte_reg;
    assign results.record_type = record_type_reg;
    assign results.record_length = record_length_reg;
    assign results.last = last_reg;

    assign crc_updated = crc_byte(running_crc_reg, b);
    assign count_inc = byte_count_reg + 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        byte_count_next = byte_count_reg;
        magic_shift_next = magic_shift_reg;
        held_type_next = held_type_reg;
        held_length_next = held_length_reg;
        running_crc_next = running_crc_reg;
        stored_crc_next = stored_crc_reg;
        has_result = 1'b0;
        res_kind = KIND_PAYLOAD;
        res_data = 8'd0;
        case (phase_reg)
            PH_PAYLOAD:
            begin
                running_crc_next = crc_updated;
                has_result = 1'b1;
                res_data = b;
                if (count_inc == held_length_reg)
                begin
                    phase_next = PH_CRC;
                    byte_count_next = 32'd0;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                stored_crc_next = {stored_crc_reg[23:0], b};
                if (byte_count_reg == 32'(CRC_BYTES - 1))
                begin
                    has_result = 1'b1;
                    res_kind = ((running_crc_reg ^ CRC_ONES) == stored_crc_next) ?
                               KIND_OK : KIND_CRC_ERROR;
                    phase_next = PH_HEADER;
                    byte_count_next = 32'd0;
                    running_crc_next = CRC_ONES;
                    stored_crc_next = 32'd0;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            default:
            begin
                running_crc_next = crc_updated;
                if (byte_count_reg < 32'(MAGIC_BYTES))
                begin
                    magic_shift_next = {magic_shift_reg[23:0], b};
                end
                else if (byte_count_reg == 32'(TYPE_INDEX))
                begin
                    held_type_next = b;
                end
                else if (byte_count_reg >= 32'(LENGTH_FIRST) &&
                         byte_count_reg < 32'(LENGTH_END))
                begin
                    held_length_next = {held_length_reg[23:0], b};
                end

                if (byte_count_reg >= 32'(HEADER_BYTES - 1))
                begin
                    if (magic_shift_next != record_magic_reg)
                    begin
                        has_result = 1'b1;
                        res_kind = KIND_BAD_MAGIC;
                        phase_next = PH_HEADER;
                        running_crc_next = CRC_ONES;
                    end
                    else
                    begin
                        phase_next = (held_length_next == 32'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                    byte_count_next = 32'd0;
                    stored_crc_next = 32'd0;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            byte_count_reg <= 32'd0;
            magic_shift_reg <= 32'd0;
            held_type_reg <= 8'd0;
            held_length_reg <= 32'd0;
            running_crc_reg <= CRC_ONES;
            stored_crc_reg <= 32'd0;
            record_magic_reg <= 32'd0;
            out_valid_reg <= 1'b0;
            kind_reg <= KIND_PAYLOAD;
            data_byte_reg <= 8'd0;
            record_type_reg <= 8'd0;
            record_length_reg <= 32'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                record_magic_reg <= cfg.data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                byte_count_reg <= byte_count_next;
                magic_shift_reg <= magic_shift_next;
                held_type_reg <= held_type_next;
                held_length_reg <= held_length_next;
                running_crc_reg <= running_crc_next;
                stored_crc_reg <= stored_crc_next;
                out_valid_reg <= has_result;
                kind_reg <= res_kind;
                data_byte_reg <= res_data;
                record_type_reg <= held_type_next;
                record_length_reg <= held_length_next;
                last_reg <= (res_kind != KIND_PAYLOAD);
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A status transaction always ends the record, and a payload transaction never does.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (kind_reg != KIND_PAYLOAD)))
        else $error("last flag disagrees with result kind");

    // Status transactions carry a zero data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_PAYLOAD) |-> (data_byte_reg == 8'd0))
        else $error("status result with nonzero data byte");

    // The payload phase is only entered with a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (held_length_reg != 32'd0))
        else $error("payload phase with zero length");

    // Every accepted payload byte shows up as a payload result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PAYLOAD) |=>
        (out_valid_reg && kind_reg == KIND_PAYLOAD && data_byte_reg == $past(b)))
        else $error("payload byte not forwarded");

    // The CRC trailer count never runs past its four bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CRC) |-> (byte_count_reg < 32'(CRC_BYTES)))
        else $error("CRC byte count out of range");

endmodule

FILE: verif/lrv_tb_pkg.sv
// CRC-32 helper shared by the log record verifier stimulus and checker.
package lrv_tb_pkg;

    import lrv_pkg::CRC_POLY;

    function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

FILE: verif/lrv_record_checker.sv
// Checker that decodes the record stream, predicts every result and compares transactions.
module lrv_record_checker
    import lrv_pkg::*;
    import lrv_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic [7:0]  rec_byte,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  record_type,
    input  logic [31:0] record_length,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          results_owed
);

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_PAYLOAD = 2'd1,
        ST_CRC     = 2'd2,
        ST_SPARE   = 2'd3
    } rx_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  record_type;
        logic [31:0] record_length;
        logic        last;
    } result_t;

    result_t     owed_results[$];
    logic [31:0] expected_magic;
    rx_state_t   st;
    logic [31:0] count;
    logic [31:0] magic_seen;
    logic [7:0]  held_type;
    logic [31:0] held_length;
    logic [31:0] crc;
    logic [31:0] crc_seen;

    task automatic owe(input kind_t k, input logic [7:0] d, input logic l);
        result_t r;
        r.kind = k;
        r.data_byte = d;
        r.record_type = held_type;
        r.record_length = held_length;
        r.last = l;
        owed_results.push_back(r);
    endtask

    task automatic restart();
        st = ST_HEADER;
        count = 0;
        crc = CRC_ONES;
        crc_seen = 0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        case (st)
            ST_PAYLOAD:
            begin
                crc = crc32_feed(crc, b);
                owe(KIND_PAYLOAD, b, 1'b0);
                count++;
                if (count == held_length)
                begin
                    st = ST_CRC;
                    count = 0;
                end
            end
            ST_CRC:
            begin
                crc_seen = {crc_seen[23:0], b};
                if (count == CRC_BYTES - 1)
                begin
                    owe(((crc ^ CRC_ONES) == crc_seen) ? KIND_OK : KIND_CRC_ERROR, 8'd0, 1'b1);
                    restart();
                end
                else
                begin
                    count++;
                end
            end
            default:
            begin
                crc = crc32_feed(crc, b);
                if (count < MAGIC_BYTES)
                begin
                    magic_seen = {magic_seen[23:0], b};
                end
                else if (count == TYPE_INDEX)
                begin
                    held_type = b;
                end
                else if (count >= LENGTH_FIRST && count < LENGTH_END)
                begin
                    held_length = {held_length[23:0], b};
                end
                if (count + 1 >= HEADER_BYTES)
                begin
                    if (magic_seen != expected_magic)
                    begin
                        owe(KIND_BAD_MAGIC, 8'd0, 1'b1);
                        restart();
                    end
                    else
                    begin
                        st = (held_length == 0) ? ST_CRC : ST_PAYLOAD;
                        count = 0;
                        crc_seen = 0;
                    end
                end
                else
                begin
                    count++;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            owed_results.delete();
            expected_magic = 0;
            magic_seen = 0;
            held_type = 0;
            held_length = 0;
            restart();
            mismatches = 0;
            results_owed = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got.kind = kind_t'(kind);
                got.data_byte = data_byte;
                got.record_type = record_type;
                got.record_length = record_length;
                got.last = last;
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, actual kind %0d data %h type %h length %h last %b",
                             $time, got.kind, got.data_byte, got.record_type,
                             got.record_length, got.last);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.record_type !== want.record_type ||
                        got.record_length !== want.record_length || got.last !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: mismatch, expected kind %0d data %h type %h length %h last %b, actual kind %0d data %h type %h length %h last %b",
                                 $time, want.kind, want.data_byte, want.record_type,
                                 want.record_length, want.last, got.kind, got.data_byte,
                                 got.record_type, got.record_length, got.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                expected_magic = cfg_data;
            end
            if (byte_valid && byte_ready)
            begin
                decode_byte(rec_byte);
            end
            results_owed = owed_results.size();
        end
    end

endmodule

FILE: verif/tb_log_record_verifier.sv
// Testbench top for the log record verifier: record stream stimulus, flow control and verdict.
module tb_log_record_verifier;

    import lrv_pkg::*;
    import lrv_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 210;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_PAYLOAD,
        FLAW_MAGIC
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          mismatches;
    int          results_owed;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;
    logic [31:0] cfg_magic = 32'd0;

    lrv_byte_if   records_if();
    lrv_result_if results_if();
    lrv_cfg_if    cfg_if();

    log_record_verifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (records_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    lrv_record_checker record_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (records_if.valid),
        .byte_ready    (records_if.ready),
        .rec_byte      (records_if.rec_byte),
        .res_valid     (results_if.valid),
        .res_ready     (results_if.ready),
        .kind          (results_if.kind),
        .data_byte     (results_if.data_byte),
        .record_type   (results_if.record_type),
        .record_length (results_if.record_length),
        .last          (results_if.last),
        .cfg_valid     (cfg_if.valid),
        .cfg_ready     (cfg_if.ready),
        .cfg_data      (cfg_if.data),
        .mismatches    (mismatches),
        .results_owed  (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                recv_steady = !recv_steady;
            end
            if (taken == 200 || taken == 500)
            begin
                wait_cycles = 200;
            end
            else
            begin
                wait_cycles = recv_steady ? 0 : $urandom_range(0, 13);
            end
            if (wait_cycles > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            @(posedge clk);
            while (!results_if.valid)
            begin
                @(posedge clk);
            end
            taken++;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            records_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        records_if.valid <= 1'b1;
        records_if.rec_byte <= b;
        @(posedge clk);
        while (!records_if.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic emit_record(input logic [31:0] magic, input logic [7:0] version,
                               input logic [7:0] rtype, input logic [31:0] length,
                               input flaw_t flaw);
        logic [7:0]  bytes[$];
        logic [31:0] crc;
        int          spot;
        for (int i = 3; i >= 0; i--)
        begin
            bytes.push_back(magic[8*i +: 8]);
        end
        bytes.push_back(version);
        bytes.push_back(rtype);
        for (int i = 3; i >= 0; i--)
        begin
            bytes.push_back(length[8*i +: 8]);
        end
        for (int i = LENGTH_END; i < HEADER_BYTES; i++)
        begin
            bytes.push_back(8'($urandom()));
        end
        if (flaw != FLAW_MAGIC)
        begin
            for (int i = 0; i < length; i++)
            begin
                bytes.push_back(8'($urandom()));
            end
            crc = CRC_ONES;
            foreach (bytes[i])
            begin
                crc = crc32_feed(crc, bytes[i]);
            end
            crc = crc ^ CRC_ONES;
            if (flaw == FLAW_CRC || (flaw == FLAW_PAYLOAD && length == 0))
            begin
                crc = crc ^ (32'd1 << $urandom_range(0, 31));
            end
            else if (flaw == FLAW_PAYLOAD)
            begin
                spot = HEADER_BYTES + $urandom_range(0, length - 1);
                bytes[spot] = bytes[spot] ^ (8'd1 << $urandom_range(0, 7));
            end
            for (int i = 3; i >= 0; i--)
            begin
                bytes.push_back(crc[8*i +: 8]);
            end
        end
        foreach (bytes[i])
        begin
            send_byte(bytes[i]);
        end
    endtask

    task automatic settle();
        records_if.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (results_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        cfg_magic = value;
    endtask

    task automatic random_phase(input int budget);
        int          start;
        int          pick;
        logic [31:0] length;
        logic [31:0] wrong;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(0, 99);
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
            wrong = ($urandom_range(0, 1) == 0) ? (cfg_magic ^ (32'd1 << $urandom_range(0, 31)))
                                                : $urandom();
            if (wrong == cfg_magic)
            begin
                wrong = ~cfg_magic;
            end
            if (pick < 60)
            begin
                emit_record(cfg_magic, $urandom(), $urandom(), length, FLAW_NONE);
            end
            else if (pick < 75)
            begin
                emit_record(cfg_magic, $urandom(), $urandom(), length, FLAW_CRC);
            end
            else if (pick < 85)
            begin
                emit_record(cfg_magic, $urandom(), $urandom(), length, FLAW_PAYLOAD);
            end
            else if (pick < 95)
            begin
                emit_record(wrong, $urandom(), $urandom(), $urandom(), FLAW_MAGIC);
            end
            else
            begin
                emit_record(wrong, $urandom(), $urandom(), $urandom(), FLAW_MAGIC);
            end
        end
    endtask

    initial
    begin
        logic [31:0] settings[5];
        settings = '{32'hFFFF_FFFF, $urandom(), 32'h0000_0000, $urandom(), $urandom()};
        rst_n = 1'b0;
        records_if.valid = 1'b0;
        records_if.rec_byte = 8'd0;
        results_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length record with all-zero header fields, then a bad magic header at the maxima.
        emit_record(32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000, FLAW_NONE);
        emit_record(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, FLAW_MAGIC);

        foreach (settings[i])
        begin
            settle();
            write_magic(settings[i]);
            random_phase(PHASE_BYTES);
        end

        settle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
